[sv/ckbc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ckbc_pkg
// Shared constants, tables and the job type of the counter keyed byte cipher.
// ----------------------------------------------------------------------------
package ckbc_pkg;

  localparam int HEADER_LEN   = 24;
  localparam int COUNT_WRAP   = 2377;
  localparam int HDR_TAB_SIZE = 24;
  localparam int HDR_N        = (HEADER_LEN > HDR_TAB_SIZE) ? HDR_TAB_SIZE : HEADER_LEN;
  localparam int HIDX_W       = $clog2(HDR_N + 1);
  localparam int TAB_IDX_W    = $clog2(HDR_TAB_SIZE);
  localparam int CNT_W        = $clog2(COUNT_WRAP + 2);

  // job queue depth, a power of two
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] HDR_TAB [HDR_TAB_SIZE] = '{
    8'd2,   8'd153, 8'd5,   8'd200, 8'd235, 8'd199, 8'd200, 8'd201,
    8'd133, 8'd3,   8'd3,   8'd3,   8'd200, 8'd201, 8'd202, 8'd3,
    8'd3,   8'd3,   8'd133, 8'd2,   8'd6,   8'd192, 8'd6,   8'd233
  };

  // key on odd bytes, indexed by count mod 7: r*(r+11) mod 7
  localparam logic [2:0] KEY7 [7] = '{
    3'd0, 3'd5, 3'd5, 3'd0, 3'd4, 3'd3, 3'd4
  };

  // key on even bytes, indexed by count mod 23: r*(r+7) mod 23
  localparam logic [4:0] KEY23 [23] = '{
    5'd0,  5'd8,  5'd18, 5'd7,  5'd21, 5'd14, 5'd9,  5'd6,
    5'd5,  5'd6,  5'd9,  5'd14, 5'd21, 5'd7,  5'd18, 5'd8,
    5'd0,  5'd17, 5'd13, 5'd11, 5'd11, 5'd13, 5'd17
  };

  typedef logic [HIDX_W-1:0] hidx_t;

  // one queued job: header bytes from hdr_from up, then the final result
  typedef struct packed {
    hidx_t      hdr_from;
    logic [7:0] data;
    logic       err;
  } job_t;

  function automatic logic [7:0] hdr_byte(hidx_t idx);
    return HDR_TAB[TAB_IDX_W'(idx)];
  endfunction

endpackage
`default_nettype wire

[sv/ckbc_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ckbc_front
// Takes input bytes, keeps the stream state and key counters, and turns each
// byte into at most one job for the back end.
// ----------------------------------------------------------------------------
module ckbc_front import ckbc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       decrypt_mode,
  input  wire logic       in_valid,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_stream_start,
  output logic            in_stall,
  input  wire logic       q_full,
  output logic            push,
  output job_t            push_job
);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [2:0]       r7_r, r7_nxt;
  logic [4:0]       r23_r, r23_nxt;
  logic             par_r, par_nxt;
  hidx_t            hidx_r, hidx_nxt;
  logic             rej_r, rej_nxt;

  logic [CNT_W-1:0] s_cnt, k_cnt;
  logic [2:0]       s_r7, k_r7;
  logic [4:0]       s_r23, k_r23;
  logic             s_par, k_par;
  hidx_t            s_hidx;
  logic             s_rej;
  logic             wrap;
  logic [7:0]       key;
  logic             accept;
  logic             produce;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    // a stream start restarts the state before the byte is handled
    s_cnt  = in_stream_start ? '0 : cnt_r;
    s_r7   = in_stream_start ? '0 : r7_r;
    s_r23  = in_stream_start ? '0 : r23_r;
    s_par  = in_stream_start ? 1'b1 : par_r;
    s_hidx = in_stream_start ? '0 : hidx_r;
    s_rej  = in_stream_start ? 1'b0 : rej_r;

    // counter step with residues mod 7 and mod 23 kept alongside
    wrap  = s_cnt > CNT_W'(COUNT_WRAP);
    k_cnt = wrap ? CNT_W'(1) : CNT_W'(s_cnt + 1'b1);
    k_r7  = wrap ? 3'd1 : ((s_r7 == 3'd6) ? 3'd0 : 3'(s_r7 + 1'b1));
    k_r23 = wrap ? 5'd1 : ((s_r23 == 5'd22) ? 5'd0 : 5'(s_r23 + 1'b1));
    k_par = ~s_par;
    key   = k_par ? 8'(KEY23[k_r23]) : 8'(KEY7[k_r7]);

    cnt_nxt  = s_cnt;
    r7_nxt   = s_r7;
    r23_nxt  = s_r23;
    par_nxt  = s_par;
    hidx_nxt = s_hidx;
    rej_nxt  = s_rej;
    produce  = 1'b0;
    push_job = '{hdr_from: hidx_t'(HDR_N), data: 8'd0, err: 1'b0};

    if (!s_rej) begin
      if (decrypt_mode) begin
        if (s_hidx < hidx_t'(HDR_N)) begin
          if (in_data_byte != hdr_byte(s_hidx)) begin
            rej_nxt      = 1'b1;
            produce      = 1'b1;
            push_job.err = 1'b1;
          end else begin
            hidx_nxt = hidx_t'(s_hidx + 1'b1);
          end
        end else begin
          cnt_nxt       = k_cnt;
          r7_nxt        = k_r7;
          r23_nxt       = k_r23;
          par_nxt       = k_par;
          produce       = 1'b1;
          push_job.data = in_data_byte - key;
        end
      end else begin
        // any header bytes not yet sent go out ahead of this byte
        cnt_nxt           = k_cnt;
        r7_nxt            = k_r7;
        r23_nxt           = k_r23;
        par_nxt           = k_par;
        hidx_nxt          = hidx_t'(HDR_N);
        produce           = 1'b1;
        push_job.hdr_from = s_hidx;
        push_job.data     = in_data_byte + key;
      end
    end
  end

  assign push = accept && produce;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      r7_r   <= '0;
      r23_r  <= '0;
      par_r  <= 1'b1;
      hidx_r <= '0;
      rej_r  <= 1'b0;
    end else if (accept) begin
      cnt_r  <= cnt_nxt;
      r7_r   <= r7_nxt;
      r23_r  <= r23_nxt;
      par_r  <= par_nxt;
      hidx_r <= hidx_nxt;
      rej_r  <= rej_nxt;
    end
  end

endmodule
`default_nettype wire

[sv/ckbc_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ckbc_queue
// Short job queue between the front end and the back end.
// ----------------------------------------------------------------------------
module ckbc_queue import ckbc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  job_t      push_job,
  input  wire logic pop,
  output logic      head_valid,
  output job_t      head_job,
  output logic      full
);

  job_t              slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign head_valid = count_r != '0;
  assign full       = count_r == QCNT_W'(QDEPTH);
  assign head_job   = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= QPTR_W'(wr_ptr_r + 1'b1);
      end
      if (pop) begin
        rd_ptr_r <= QPTR_W'(rd_ptr_r + 1'b1);
      end
      if (push && !pop) begin
        count_r <= QCNT_W'(count_r + 1'b1);
      end else if (pop && !push) begin
        count_r <= QCNT_W'(count_r - 1'b1);
      end
    end
  end

endmodule
`default_nettype wire

[sv/ckbc_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ckbc_back
// Expands the head job into header bytes and its final result, one per cycle
// while out_stall is low, into the output register.
// ----------------------------------------------------------------------------
module ckbc_back import ckbc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic head_valid,
  input  job_t      head_job,
  output logic      pop,
  output logic      out_valid,
  input  wire logic out_stall,
  output logic [7:0] out_byte,
  output logic      out_header_error,
  output logic      out_last_of_run
);

  logic       sub_act_r;
  hidx_t      sub_idx_r;
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       err_r;
  logic       last_r;

  logic  load;
  hidx_t idx;
  logic  in_hdr;

  always_comb begin
    load   = head_valid && (!out_valid_r || !out_stall);
    idx    = sub_act_r ? sub_idx_r : head_job.hdr_from;
    in_hdr = idx < hidx_t'(HDR_N);
    pop    = load && !in_hdr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_act_r   <= 1'b0;
      sub_idx_r   <= '0;
      out_valid_r <= 1'b0;
      out_byte_r  <= 8'd0;
      err_r       <= 1'b0;
      last_r      <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
      if (in_hdr) begin
        out_byte_r <= hdr_byte(idx);
        err_r      <= 1'b0;
        last_r     <= 1'b0;
        sub_idx_r  <= hidx_t'(idx + 1'b1);
        sub_act_r  <= 1'b1;
      end else begin
        out_byte_r <= head_job.data;
        err_r      <= head_job.err;
        last_r     <= 1'b1;
        sub_act_r  <= 1'b0;
      end
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_byte         = out_byte_r;
  assign out_header_error = err_r;
  assign out_last_of_run  = last_r;

endmodule
`default_nettype wire

[sv/counter_keyed_byte_cipher.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// counter_keyed_byte_cipher
// Byte stream cipher with a fixed header and a position keyed add/subtract.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  in_      input      in_valid / in_stall  in_data_byte, in_stream_start
//  out_     output     out_valid/out_stall  out_byte, out_header_error,
//                                           out_last_of_run
//  cfg_     input      cfg_valid/cfg_ready  cfg_decrypt_mode
//
//  one byte per cycle in and out while out_stall is low and each byte gives
//  one result; the first encrypt byte of a stream gives 25 results, one per
//  cycle from the back end; the 4-entry job queue stalls the input once it
//  fills; each result passes through the job queue and the output register
//  synchronous reset puts the stream state as at a fresh stream start
// ----------------------------------------------------------------------------
module counter_keyed_byte_cipher import ckbc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_stream_start,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            out_header_error,
  output logic            out_last_of_run,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       cfg_decrypt_mode
);

  logic decrypt_mode_r;
  logic push;
  job_t push_job;
  logic pop;
  logic head_valid;
  job_t head_job;
  logic q_full;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decrypt_mode_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      decrypt_mode_r <= cfg_decrypt_mode;
    end
  end

  ckbc_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .decrypt_mode    (decrypt_mode_r),
    .in_valid        (in_valid),
    .in_data_byte    (in_data_byte),
    .in_stream_start (in_stream_start),
    .in_stall        (in_stall),
    .q_full          (q_full),
    .push            (push),
    .push_job        (push_job)
  );

  ckbc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job),
    .full       (q_full)
  );

  ckbc_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_valid       (head_valid),
    .head_job         (head_job),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .out_header_error (out_header_error),
    .out_last_of_run  (out_last_of_run)
  );

  // an error result is a lone zero byte, and only in decrypt mode
  a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_header_error |-> out_last_of_run && out_byte == 8'd0 && decrypt_mode_r)
    else $error("header error result malformed");

  // a header burst continues without a gap once a byte of it is taken
  a_burst_gapless: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_of_run |=> out_valid)
    else $error("gap inside a header burst");

  // multi-result runs only come from encrypt mode
  a_burst_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_of_run |-> !decrypt_mode_r)
    else $error("header burst in decrypt mode");

endmodule
`default_nettype wire
